// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the monitor core modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ABCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ABCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/abcm_pkg.sv =====
package abcm_pkg;

	// Field widths of the sample and result channels.
	localparam int RAW_W   = 12;
	localparam int OUT_W   = 16;

	// Register widths.
	localparam int VREF_W  = 13;
	localparam int RATIO_W = 16;
	localparam int ZERO_W  = 13;
	localparam int GAIN_W  = 16;
	localparam int ALPHA_W = 9;

	// ADC resolution used for the millivolt scaling.
	localparam int ADC_BITS = 12;

	// Fixed-point formats.
	localparam int FRAC_BITS = 8;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
	localparam int ALPHA_ONE = 1 << FRAC_BITS;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	// Derived datapath widths.
	localparam int MV_W  = RAW_W + VREF_W - ADC_BITS;
	localparam int MAG_W = (MV_W > ZERO_W) ? MV_W : ZERO_W;
	localparam int MUL_A_W0 = (MAG_W > RAW_W) ? MAG_W : RAW_W;
	localparam int MUL_A_W  = (MUL_A_W0 > ALPHA_W) ? MUL_A_W0 : ALPHA_W;
	localparam int MUL_B_W0 = (VREF_W > RATIO_W) ? VREF_W : RATIO_W;
	localparam int MUL_B_W1 = (MUL_B_W0 > GAIN_W) ? MUL_B_W0 : GAIN_W;
	localparam int MUL_B_W  = (MUL_B_W1 > OUT_W) ? MUL_B_W1 : OUT_W;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	// Configuration bus.
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = ADDR_W - 2;

	// Register reset values.
	localparam logic [VREF_W-1:0]  VREF_RST  = VREF_W'(3300);
	localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(1024);
	localparam logic [ZERO_W-1:0]  ZERO_RST  = ZERO_W'(1650);
	localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(256);
	localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(26);

	// Register indexes (byte address is four times the index).
	typedef enum logic [IDX_W-1:0] {
		REG_VREF      = 3'd0,
		REG_RATIO     = 3'd1,
		REG_ZERO      = 3'd2,
		REG_GAIN      = 3'd3,
		REG_ALPHA     = 3'd4,
		REG_CAL_EN    = 3'd5
	} reg_idx_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [VREF_W-1:0]  vref_mv;
		logic [RATIO_W-1:0] battery_ratio_q8;
		logic [ZERO_W-1:0]  zero_offset_mv;
		logic [GAIN_W-1:0]  current_gain_q8;
		logic [ALPHA_W-1:0] filter_alpha_q8;
		logic               calibration_enable;
	} cfg_t;

	// Operation of the shared multiplier.
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_BAT_MV,
		MUL_LEFT_MV,
		MUL_RIGHT_MV,
		MUL_BAT,
		MUL_LEFT_MA,
		MUL_RIGHT_MA,
		MUL_LEFT_EMA,
		MUL_RIGHT_EMA
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		mul_op_t mul_op;
		logic    mag_en;
		logic    diff_left_en;
		logic    diff_right_en;
		logic    finish;
	} cmd_t;

endpackage

// ===== rtl/core/abcm_in_if.sv =====
interface abcm_in_if;
	logic                       valid;
	logic                       ready;
	logic [abcm_pkg::RAW_W-1:0] bat_count;
	logic [abcm_pkg::RAW_W-1:0] left_count;
	logic [abcm_pkg::RAW_W-1:0] right_count;

	modport source (
		output valid, bat_count, left_count, right_count,
		input  ready
	);

	modport sink (
		input  valid, bat_count, left_count, right_count,
		output ready
	);
endinterface

// ===== rtl/core/abcm_out_if.sv =====
interface abcm_out_if;
	logic                       valid;
	logic                       ready;
	logic [abcm_pkg::OUT_W-1:0] battery_mv;
	logic [abcm_pkg::OUT_W-1:0] left_current_ma;
	logic [abcm_pkg::OUT_W-1:0] right_current_ma;
	logic                       currents_ok;

	modport source (
		output valid, battery_mv, left_current_ma, right_current_ma, currents_ok,
		input  ready
	);

	modport sink (
		input  valid, battery_mv, left_current_ma, right_current_ma, currents_ok,
		output ready
	);
endinterface

// ===== rtl/core/abcm_regs.sv =====
module abcm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abcm_pkg::ADDR_W-1:0]   paddr,
	input  logic [abcm_pkg::DATA_W-1:0]   pwdata,
	output logic [abcm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output abcm_pkg::cfg_t                cfg
);
	import abcm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Register writes in the access phase; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vref_mv            <= VREF_RST;
			cfg_q.battery_ratio_q8   <= RATIO_RST;
			cfg_q.zero_offset_mv     <= ZERO_RST;
			cfg_q.current_gain_q8    <= GAIN_RST;
			cfg_q.filter_alpha_q8    <= ALPHA_RST;
			cfg_q.calibration_enable <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				REG_VREF:   cfg_q.vref_mv            <= pwdata[VREF_W-1:0];
				REG_RATIO:  cfg_q.battery_ratio_q8   <= pwdata[RATIO_W-1:0];
				REG_ZERO:   cfg_q.zero_offset_mv     <= pwdata[ZERO_W-1:0];
				REG_GAIN:   cfg_q.current_gain_q8    <= pwdata[GAIN_W-1:0];
				REG_ALPHA:  cfg_q.filter_alpha_q8    <= pwdata[ALPHA_W-1:0];
				REG_CAL_EN: cfg_q.calibration_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (idx)
			REG_VREF:   prdata = DATA_W'(cfg_q.vref_mv);
			REG_RATIO:  prdata = DATA_W'(cfg_q.battery_ratio_q8);
			REG_ZERO:   prdata = DATA_W'(cfg_q.zero_offset_mv);
			REG_GAIN:   prdata = DATA_W'(cfg_q.current_gain_q8);
			REG_ALPHA:  prdata = DATA_W'(cfg_q.filter_alpha_q8);
			REG_CAL_EN: prdata = DATA_W'(cfg_q.calibration_enable);
			default:    prdata = '0;
		endcase
	end
endmodule

// ===== rtl/core/abcm_ctrl.sv =====
`include "assert_macros.svh"

module abcm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output abcm_pkg::cmd_t cmd
);
	import abcm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BAT_MV,
		S_LEFT_MV,
		S_RIGHT_MV,
		S_BAT,
		S_LEFT_MA,
		S_RIGHT_MA,
		S_LEFT_EMA,
		S_RIGHT_EMA,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   finish;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// The result register is free when empty or being drained this cycle.
	assign finish    = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// Command decode: one multiplier operation per computing state (none in idle or finish), plus side updates.
	always_comb begin
		cmd               = '0;
		cmd.mul_op        = MUL_NONE;
		cmd.capture       = in_fire;
		cmd.finish        = finish;
		unique case (state_q)
			S_IDLE:      cmd.mul_op = MUL_NONE;
			S_BAT_MV:    cmd.mul_op = MUL_BAT_MV;
			S_LEFT_MV:   cmd.mul_op = MUL_LEFT_MV;
			S_RIGHT_MV:  cmd.mul_op = MUL_RIGHT_MV;
			S_BAT: begin
				cmd.mul_op = MUL_BAT;
				cmd.mag_en = 1'b1;
			end
			S_LEFT_MA:   cmd.mul_op = MUL_LEFT_MA;
			S_RIGHT_MA: begin
				cmd.mul_op       = MUL_RIGHT_MA;
				cmd.diff_left_en = 1'b1;
			end
			S_LEFT_EMA: begin
				cmd.mul_op        = MUL_LEFT_EMA;
				cmd.diff_right_en = 1'b1;
			end
			S_RIGHT_EMA: cmd.mul_op = MUL_RIGHT_EMA;
			S_FINISH:    cmd.mul_op = MUL_NONE;
			default:     cmd.mul_op = MUL_NONE;
		endcase
	end

	// Sequencer and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:      if (in_fire) state_q <= S_BAT_MV;
				S_BAT_MV:    state_q <= S_LEFT_MV;
				S_LEFT_MV:   state_q <= S_RIGHT_MV;
				S_RIGHT_MV:  state_q <= S_BAT;
				S_BAT:       state_q <= S_LEFT_MA;
				S_LEFT_MA:   state_q <= S_RIGHT_MA;
				S_RIGHT_MA:  state_q <= S_LEFT_EMA;
				S_LEFT_EMA:  state_q <= S_RIGHT_EMA;
				S_RIGHT_EMA: state_q <= S_FINISH;
				S_FINISH:    if (finish) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	`ABCM_ASSERT_NEXT(a_ctrl_start, in_fire, state_q == S_BAT_MV, "accepted sample set did not start the sequence")
	`ABCM_ASSERT_NEXT(a_ctrl_load, finish, out_valid_q && state_q == S_IDLE, "finished result not presented")
endmodule

// ===== rtl/core/abcm_dp.sv =====
`include "assert_macros.svh"

module abcm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  abcm_pkg::cfg_t              cfg,
	input  abcm_pkg::cmd_t              cmd,
	input  logic [abcm_pkg::RAW_W-1:0]  bat_count,
	input  logic [abcm_pkg::RAW_W-1:0]  left_count,
	input  logic [abcm_pkg::RAW_W-1:0]  right_count,
	output logic [abcm_pkg::OUT_W-1:0]  battery_mv,
	output logic [abcm_pkg::OUT_W-1:0]  left_current_ma,
	output logic [abcm_pkg::OUT_W-1:0]  right_current_ma,
	output logic                        currents_ok
);
	import abcm_pkg::*;

	// Drop the fraction and clamp to the output range.
	function automatic logic [OUT_W-1:0] sat_out(input logic [PROD_W-1:0] p);
		if (|p[PROD_W-1:FRAC_BITS+OUT_W]) begin
			return OUT_MAX;
		end
		return p[FRAC_BITS +: OUT_W];
	endfunction

	function automatic logic [MAG_W-1:0] abs_diff(input logic [MAG_W-1:0] x,
	                                             input logic [MAG_W-1:0] y);
		return (x >= y) ? (x - y) : (y - x);
	endfunction

	// One filter update from the stored difference step, or a hold or a direct load.
	function automatic logic [OUT_W-1:0] ema_next(input logic [OUT_W-1:0] prev,
	                                             input logic [OUT_W-1:0] sample,
	                                             input logic [OUT_W-1:0] step,
	                                             input logic             up,
	                                             input logic             hold,
	                                             input logic             load);
		if (hold) begin
			return prev;
		end
		if (load) begin
			return sample;
		end
		return up ? (prev + step) : (prev - step);
	endfunction

	// Captured sample set and intermediate results.
	logic [RAW_W-1:0]  raw_bat_q, raw_left_q, raw_right_q;
	logic [MV_W-1:0]   mv_bat_q, mv_left_q, mv_right_q;
	logic [MAG_W-1:0]  mag_left_q, mag_right_q;
	logic [OUT_W-1:0]  bat_q, sample_left_q, sample_right_q;
	logic [OUT_W-1:0]  diff_left_q, diff_right_q;
	logic              up_left_q, up_right_q;
	logic [OUT_W-1:0]  step_left_q, step_right_q;

	// Filter state and result register.
	logic [OUT_W-1:0]  filt_left_q, filt_right_q;
	logic              started_q;
	logic [OUT_W-1:0]  bat_out_q;
	logic              cur_valid_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  prod_rnd;
	logic               cur_en;
	logic               alpha_zero;
	logic               alpha_load;

	assign cur_en     = cfg.calibration_enable && (cfg.current_gain_q8 != '0);
	assign alpha_zero = (cfg.filter_alpha_q8 == '0);
	assign alpha_load = (cfg.filter_alpha_q8 >= ALPHA_W'(ALPHA_ONE)) || !started_q;

	// Operand select for the shared multiplier.
	always_comb begin
		unique case (cmd.mul_op)
			MUL_BAT_MV: begin
				mul_a = MUL_A_W'(raw_bat_q);
				mul_b = MUL_B_W'(cfg.vref_mv);
			end
			MUL_LEFT_MV: begin
				mul_a = MUL_A_W'(raw_left_q);
				mul_b = MUL_B_W'(cfg.vref_mv);
			end
			MUL_RIGHT_MV: begin
				mul_a = MUL_A_W'(raw_right_q);
				mul_b = MUL_B_W'(cfg.vref_mv);
			end
			MUL_BAT: begin
				mul_a = MUL_A_W'(mv_bat_q);
				mul_b = MUL_B_W'(cfg.battery_ratio_q8);
			end
			MUL_LEFT_MA: begin
				mul_a = MUL_A_W'(mag_left_q);
				mul_b = MUL_B_W'(cfg.current_gain_q8);
			end
			MUL_RIGHT_MA: begin
				mul_a = MUL_A_W'(mag_right_q);
				mul_b = MUL_B_W'(cfg.current_gain_q8);
			end
			MUL_LEFT_EMA: begin
				mul_a = MUL_A_W'(cfg.filter_alpha_q8);
				mul_b = MUL_B_W'(diff_left_q);
			end
			MUL_RIGHT_EMA: begin
				mul_a = MUL_A_W'(cfg.filter_alpha_q8);
				mul_b = MUL_B_W'(diff_right_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign prod_rnd = prod + PROD_W'(ROUND_HALF);

	// Payload registers written by the sequence.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_bat_q   <= bat_count;
			raw_left_q  <= left_count;
			raw_right_q <= right_count;
		end
		case (cmd.mul_op)
			MUL_BAT_MV:    mv_bat_q       <= prod[ADC_BITS +: MV_W];
			MUL_LEFT_MV:   mv_left_q      <= prod[ADC_BITS +: MV_W];
			MUL_RIGHT_MV:  mv_right_q     <= prod[ADC_BITS +: MV_W];
			MUL_BAT:       bat_q          <= sat_out(prod);
			MUL_LEFT_MA:   sample_left_q  <= sat_out(prod);
			MUL_RIGHT_MA:  sample_right_q <= sat_out(prod);
			MUL_LEFT_EMA:  step_left_q    <= prod_rnd[FRAC_BITS +: OUT_W];
			MUL_RIGHT_EMA: step_right_q   <= prod_rnd[FRAC_BITS +: OUT_W];
			default: ;
		endcase
		// Offset removal runs beside the battery product.
		if (cmd.mag_en) begin
			mag_left_q  <= abs_diff(MAG_W'(mv_left_q), MAG_W'(cfg.zero_offset_mv));
			mag_right_q <= abs_diff(MAG_W'(mv_right_q), MAG_W'(cfg.zero_offset_mv));
		end
		// Distance from the filtered value to the new sample.
		if (cmd.diff_left_en) begin
			up_left_q   <= (sample_left_q >= filt_left_q);
			diff_left_q <= (sample_left_q >= filt_left_q) ? (sample_left_q - filt_left_q)
			                                               : (filt_left_q - sample_left_q);
		end
		if (cmd.diff_right_en) begin
			up_right_q   <= (sample_right_q >= filt_right_q);
			diff_right_q <= (sample_right_q >= filt_right_q) ? (sample_right_q - filt_right_q)
			                                                  : (filt_right_q - sample_right_q);
		end
	end

	// Filter state and result register, updated once per sample set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_left_q  <= '0;
			filt_right_q <= '0;
			started_q    <= 1'b0;
			bat_out_q    <= '0;
			cur_valid_q  <= 1'b0;
		end else if (cmd.finish) begin
			bat_out_q   <= bat_q;
			cur_valid_q <= cur_en;
			started_q   <= cur_en;
			if (cur_en) begin
				filt_left_q  <= ema_next(filt_left_q, sample_left_q, step_left_q,
				                         up_left_q, alpha_zero, alpha_load);
				filt_right_q <= ema_next(filt_right_q, sample_right_q, step_right_q,
				                         up_right_q, alpha_zero, alpha_load);
			end else begin
				filt_left_q  <= '0;
				filt_right_q <= '0;
			end
		end
	end

	assign battery_mv       = bat_out_q;
	assign left_current_ma  = filt_left_q;
	assign right_current_ma = filt_right_q;
	assign currents_ok      = cur_valid_q;

	`ABCM_ASSERT_NEXT(a_dp_disable_clear, cmd.finish && !cur_en, !started_q && filt_left_q == '0 && filt_right_q == '0 && !cur_valid_q, "disabled currents not cleared")
	`ABCM_ASSERT_NEXT(a_dp_ema_bound, cmd.finish && cur_en && !alpha_zero && !alpha_load, (filt_left_q >= $past(filt_left_q) && filt_left_q <= $past(sample_left_q)) || (filt_left_q <= $past(filt_left_q) && filt_left_q >= $past(sample_left_q)), "filtered value left the sample interval")
endmodule

// ===== rtl/core/adc_battery_current_monitor_core.sv =====
// Sample sets are taken only while the sequencer is idle; each one passes through
// eight products that share one multiplier and then a result-load step, so a new
// set is not accepted until the last result is loaded. A stalled result holds the
// sequencer in its final step until the result register drains.
// Reset (arst_n low, asynchronous): configuration registers return to defaults;
// filters clear to zero, then take the next sample directly unless alpha is zero.
module adc_battery_current_monitor_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abcm_pkg::ADDR_W-1:0] paddr,
	input  logic [abcm_pkg::DATA_W-1:0] pwdata,
	output logic [abcm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	abcm_in_if.sink                     samples,
	abcm_out_if.source                  results
);
	import abcm_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	// Configuration registers.
	abcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer and handshakes.
	abcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// Arithmetic and filter state.
	abcm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.bat_count         (samples.bat_count),
		.left_count        (samples.left_count),
		.right_count       (samples.right_count),
		.battery_mv        (results.battery_mv),
		.left_current_ma   (results.left_current_ma),
		.right_current_ma  (results.right_current_ma),
		.currents_ok       (results.currents_ok)
	);
endmodule
